>>> sv/fmp_pkg.sv
package fmp_pkg;

	// Width of the result port, fixed by the interface
	localparam int unsigned VALUE_WIDTH = 16;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIND,
		ST_DIV_LOAD,
		ST_DIV,
		ST_WALK
	} fmp_state_t;

	// Status returned by the serial remainder unit
	typedef struct packed {
		logic busy;
		logic done;
	} fmp_div_stat_t;

endpackage

>>> sv/fibonacci_modulo_pisano_core.sv
// Fibonacci modulo m with Pisano-period reduction.
//
// Input: pulse start with index while busy is low; the transaction is taken
// at that edge and busy stays high until the result is out. The result is
// presented on value with done high for exactly one cycle; there is no
// back-pressure, the receiver must take it then.
// Configuration: cfg_data is written into the modulus when cfg_valid and
// cfg_ready are high (cfg_ready is high while idle). A write drops the
// cached period. A modulus of zero acts as one and yields zero.
// Steps per transaction, from accept to done:
//   period search (only first item after reset or a modulus write):
//     P = Pisano period of m (at most 6m), one modular add per step
//   remainder index mod P: serial restoring unit
//   walk: k = index mod P, one modular add per step
// All steps of the recurrence share one modular adder. One item at a time.
// Reset: modulus is 2, no period cached, busy and done low.
module fibonacci_modulo_pisano_core #(
	parameter int unsigned INDEX_WIDTH   = 32,
	parameter int unsigned MODULUS_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [INDEX_WIDTH-1:0]               index,
	output logic                                 busy,
	output logic                                 done,
	output logic [fmp_pkg::VALUE_WIDTH-1:0]      value,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [MODULUS_WIDTH-1:0]             cfg_data
);
	import fmp_pkg::*;

	localparam int unsigned PW = MODULUS_WIDTH + 3;
	localparam int unsigned XW = (MODULUS_WIDTH > VALUE_WIDTH) ? MODULUS_WIDTH : VALUE_WIDTH;

	fmp_state_t state_q, state_d;

	logic [MODULUS_WIDTH-1:0] modulus_q;
	logic                     known_q;
	logic [PW-1:0]            period_q;
	logic [PW-1:0]            limit_q;
	logic [PW-1:0]            cnt_q;
	logic [PW-1:0]            cnt_inc;
	logic [MODULUS_WIDTH-1:0] a_q, b_q;
	logic [MODULUS_WIDTH-1:0] sum;
	logic [MODULUS_WIDTH-1:0] m_eff;
	logic                     m_small;
	logic [INDEX_WIDTH-1:0]   index_q;
	logic                     done_q;
	logic [VALUE_WIDTH-1:0]   value_q;
	logic [XW-1:0]            a_ext;
	logic                     find_end;
	logic                     div_start;
	fmp_div_stat_t            div_stat;
	logic [PW-1:0]            rem;

	// Effective modulus: zero behaves as one
	assign m_eff   = (modulus_q == '0) ? MODULUS_WIDTH'(1) : modulus_q;
	assign m_small = (modulus_q <= MODULUS_WIDTH'(1));
	assign cnt_inc = cnt_q + PW'(1);

	// Shared modular adder
	fmp_modadd #(
		.MODULUS_WIDTH(MODULUS_WIDTH)
	) u_modadd (
		.a  (a_q),
		.b  (b_q),
		.m  (m_eff),
		.sum(sum)
	);

	// Serial remainder of index by period
	fmp_divider #(
		.DIVIDEND_WIDTH(INDEX_WIDTH),
		.DIVISOR_WIDTH (PW)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (index_q),
		.divisor  (period_q),
		.stat     (div_stat),
		.remainder(rem)
	);

	// Period search ends when the pair returns to (0,1) or the bound is hit
	assign find_end = ((b_q == '0) && (sum == MODULUS_WIDTH'(1))) || (cnt_inc >= limit_q);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (!known_q && !m_small) begin
						state_d = ST_FIND;
					end else begin
						state_d = ST_DIV_LOAD;
					end
				end
			end
			ST_FIND: begin
				if (find_end) begin
					state_d = ST_DIV_LOAD;
				end
			end
			ST_DIV_LOAD: state_d = ST_DIV;
			ST_DIV: begin
				if (div_stat.done) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (cnt_q == '0) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		busy      = (state_q != ST_IDLE);
		cfg_ready = (state_q == ST_IDLE);
		div_start = (state_q == ST_DIV_LOAD);
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			modulus_q <= MODULUS_WIDTH'(2);
			known_q   <= 1'b0;
			period_q  <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_WALK) && (cnt_q == '0);
			if (cfg_valid && cfg_ready) begin
				modulus_q <= cfg_data;
				known_q   <= 1'b0;
			end else if (state_q == ST_IDLE && start && !known_q && m_small) begin
				period_q <= PW'(1);
				known_q  <= 1'b1;
			end else if (state_q == ST_FIND && find_end) begin
				period_q <= cnt_inc;
				known_q  <= 1'b1;
			end
		end
	end

	// Recurrence pair, step counter and captured index
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					index_q <= index;
					a_q     <= '0;
					b_q     <= MODULUS_WIDTH'(1);
					cnt_q   <= '0;
					limit_q <= (PW'(m_eff) << 2) + (PW'(m_eff) << 1) + PW'(6);
				end
			end
			ST_FIND, ST_WALK: begin
				a_q <= b_q;
				b_q <= sum;
				if (state_q == ST_FIND) begin
					cnt_q <= cnt_inc;
				end else if (cnt_q != '0) begin
					cnt_q <= cnt_q - PW'(1);
				end
			end
			ST_DIV: begin
				if (div_stat.done) begin
					a_q   <= '0;
					b_q   <= m_small ? '0 : MODULUS_WIDTH'(1);
					cnt_q <= rem;
				end
			end
			default: begin
			end
		endcase
	end

	// Result register
	assign a_ext = XW'(a_q);
	always_ff @(posedge clk) begin
		if (state_q == ST_WALK && cnt_q == '0) begin
			value_q <= a_ext[VALUE_WIDTH-1:0];
		end
	end

	assign done  = done_q;
	assign value = value_q;

endmodule

>>> sv/fmp_modadd.sv
// Modular add: (a + b) mod m for a, b < m, one compare and subtract.
module fmp_modadd #(
	parameter int unsigned MODULUS_WIDTH = 16
) (
	input  logic [MODULUS_WIDTH-1:0] a,
	input  logic [MODULUS_WIDTH-1:0] b,
	input  logic [MODULUS_WIDTH-1:0] m,
	output logic [MODULUS_WIDTH-1:0] sum
);

	logic [MODULUS_WIDTH:0] raw;

	always_comb begin
		raw = {1'b0, a} + {1'b0, b};
		if (raw >= {1'b0, m}) begin
			raw = raw - {1'b0, m};
		end
		sum = raw[MODULUS_WIDTH-1:0];
	end

endmodule

>>> sv/fmp_divider.sv
// Restoring remainder unit: dividend mod divisor, one quotient bit per cycle.
module fmp_divider #(
	parameter int unsigned DIVIDEND_WIDTH = 32,
	parameter int unsigned DIVISOR_WIDTH  = 19
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [DIVIDEND_WIDTH-1:0]  dividend,
	input  logic [DIVISOR_WIDTH-1:0]   divisor,
	output fmp_pkg::fmp_div_stat_t     stat,
	output logic [DIVISOR_WIDTH-1:0]   remainder
);
	import fmp_pkg::*;

	localparam int unsigned CW = $clog2(DIVIDEND_WIDTH + 1);

	logic [CW-1:0]             cnt_q;
	logic                      done_q;
	logic [DIVIDEND_WIDTH-1:0] num_q;
	logic [DIVISOR_WIDTH-1:0]  rem_q;
	logic [DIVISOR_WIDTH:0]    trial;
	logic [DIVISOR_WIDTH:0]    diff;
	logic [DIVISOR_WIDTH-1:0]  rem_next;

	// One restoring step: shift in next dividend bit, subtract if it fits
	always_comb begin
		trial = {rem_q, num_q[DIVIDEND_WIDTH-1]};
		diff  = trial - {1'b0, divisor};
		if (trial >= {1'b0, divisor}) begin
			rem_next = diff[DIVISOR_WIDTH-1:0];
		end else begin
			rem_next = trial[DIVISOR_WIDTH-1:0];
		end
	end

	// Control: step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(DIVIDEND_WIDTH);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			num_q <= {num_q[DIVIDEND_WIDTH-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;
	assign remainder = rem_q;

endmodule
